FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the LZ window decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/tlzwd_pkg.sv
// ----------------------------------------------------------------------------
// tlzwd_pkg
// Types and constants shared by the LZ window decoder modules.
// ----------------------------------------------------------------------------
package tlzwd_pkg;

	// Decoder phase codes
	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_RUN    = 2'd1;
	localparam logic [1:0] PH_DIST   = 2'd2;

	// Token kinds, taken from the top two header bits
	localparam logic [1:0] KIND_LITERAL = 2'b00;
	localparam logic [1:0] KIND_RUN     = 2'b01;
	localparam logic [1:0] KIND_SHORT   = 2'b10;
	localparam logic [1:0] KIND_LONG    = 2'b11;

	// Register indexes on the configuration port
	localparam logic [1:0] CFG_START_ADDRESS    = 2'd0;
	localparam logic [1:0] CFG_PALETTE_OFFSET   = 2'd1;
	localparam logic [1:0] CFG_TRANSPARENT_ZERO = 2'd2;

	// What an accepted request asks of the sequencer
	typedef enum logic [1:0] {
		ACT_NONE,
		ACT_LITERAL,
		ACT_COPY
	} act_t;

	typedef struct packed {
		logic accept;   // request taken this cycle
		logic rd_en;    // read window at back-reference source
		logic push;     // store and emit one raw byte
		logic finish;   // last raw byte of the request
	} cmd_t;

	typedef struct packed {
		act_t act;        // decoded action of the byte on the input
		logic push_final; // byte about to be pushed ends the request
		logic out_free;   // output register can take a result
	} status_t;

endpackage

FILE: rtl/tlzwd_ctrl.sv
// ----------------------------------------------------------------------------
// tlzwd_ctrl
// Sequencer: accepts requests, steps back-reference copies byte by byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlzwd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tlzwd_pkg::status_t sts,
	output tlzwd_pkg::cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_PUSH
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		in_ready = (state_q == ST_IDLE);
		cmd.accept = in_ready & in_valid;
		case (state_q)
			ST_READ: begin
				cmd.rd_en = 1'b1;
			end
			ST_PUSH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.finish = sts.push_final;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						case (sts.act)
							tlzwd_pkg::ACT_LITERAL: state_q <= ST_PUSH;
							tlzwd_pkg::ACT_COPY:    state_q <= ST_READ;
							default:                state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (sts.out_free) begin
						state_q <= sts.push_final ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`ASSERT_IMPLIES(a_push_needs_room, clk, arst_n, cmd.push, sts.out_free)
	`ASSERT_NEXT(a_finish_returns_idle, clk, arst_n, cmd.finish, in_ready)

endmodule

FILE: rtl/tlzwd_datapath.sv
// ----------------------------------------------------------------------------
// tlzwd_datapath
// Token decode, history window, byte pairing and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tlzwd_datapath #(
	parameter int WINDOW_BYTES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tlzwd_pkg::cmd_t    cmd,
	output tlzwd_pkg::status_t sts,
	input  logic [7:0]         comp_byte,
	input  logic               last_byte,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        out_address,
	output logic [7:0]         pixel_first,
	output logic [7:0]         pixel_second,
	output logic [1:0]         byte_count,
	output logic               run_end
);

	localparam int AW = $clog2(WINDOW_BYTES);
	localparam logic [AW:0]   WIN_SIZE = (AW + 1)'(WINDOW_BYTES);
	localparam logic [AW-1:0] WP_MAX   = AW'(WINDOW_BYTES - 1);

	// Configuration
	logic [15:0] start_q;
	logic [7:0]  palette_q;
	logic        transp_q;

	// Stream state
	logic [1:0]    phase_q;
	logic [6:0]    run_left_q;
	logic [6:0]    pend_len_q;
	logic [AW-1:0] wp_q;
	logic [15:0]   emit_cnt_q;
	logic          last_q;
	logic          src_mem_q;
	logic [6:0]    copy_left_q;
	logic          pair_full_q;
	logic          out_valid_q;

	// Payload
	logic [7:0]  lit_q;
	logic [8:0]  dist_q;
	logic [7:0]  rd_data_q;
	logic [7:0]  pair_pix_q;
	logic [15:0] pair_addr_q;
	logic [15:0] out_addr_q;
	logic [7:0]  out_first_q;
	logic [7:0]  out_second_q;
	logic [1:0]  out_count_q;
	logic        out_end_q;

	logic [7:0] win_mem [WINDOW_BYTES];

	// Decode of the byte on the input
	tlzwd_pkg::act_t dec_act;
	logic [1:0]      dec_phase;
	logic [6:0]      dec_run_left;
	logic [6:0]      dec_pend_len;
	logic [7:0]      dec_lit;
	logic [6:0]      dec_copy_len;
	logic [8:0]      dec_dist;

	logic [AW:0]     back_diff;
	logic [AW-1:0]   rd_addr;
	logic [AW-1:0]   wp_next;
	logic [7:0]      raw;
	logic [7:0]      pix;
	logic [15:0]     cur_addr;
	logic            out_free;
	logic            cfg_we;

	function automatic logic [7:0] recolor(input logic [7:0] value, input logic [7:0] offset,
			input logic transparent);
		logic [7:0] sum;
		sum = value + offset;
		return (transparent && (value == 8'd0)) ? 8'd0 : sum;
	endfunction

	always_comb begin
		dec_act      = tlzwd_pkg::ACT_NONE;
		dec_phase    = tlzwd_pkg::PH_HEADER;
		dec_run_left = run_left_q;
		dec_pend_len = pend_len_q;
		dec_lit      = comp_byte;
		dec_copy_len = pend_len_q;
		dec_dist     = {1'b0, comp_byte} + 9'd1;
		case (phase_q)
			tlzwd_pkg::PH_RUN: begin
				dec_act = tlzwd_pkg::ACT_LITERAL;
				dec_run_left = (run_left_q != 7'd0) ? run_left_q - 7'd1 : 7'd0;
				dec_phase = (dec_run_left == 7'd0) ? tlzwd_pkg::PH_HEADER : tlzwd_pkg::PH_RUN;
			end
			tlzwd_pkg::PH_DIST: begin
				dec_act = tlzwd_pkg::ACT_COPY;
				dec_pend_len = 7'd0;
			end
			default: begin
				case (comp_byte[7:6])
					tlzwd_pkg::KIND_LITERAL: begin
						dec_act = tlzwd_pkg::ACT_LITERAL;
						dec_lit = {2'b00, comp_byte[5:0]};
					end
					tlzwd_pkg::KIND_RUN: begin
						dec_run_left = {1'b0, comp_byte[5:0]} + 7'd1;
						dec_phase = tlzwd_pkg::PH_RUN;
					end
					tlzwd_pkg::KIND_SHORT: begin
						dec_act = tlzwd_pkg::ACT_COPY;
						dec_copy_len = {5'd0, comp_byte[5:4]} + 7'd3;
						dec_dist = {5'd0, comp_byte[3:0]} + 9'd1;
					end
					default: begin
						dec_pend_len = {1'b0, comp_byte[5:0]} + 7'd4;
						dec_phase = tlzwd_pkg::PH_DIST;
					end
				endcase
			end
		endcase
	end

	// Back-reference source, wrapped into the window
	assign back_diff = {1'b0, wp_q} - (AW + 1)'(dist_q);
	assign rd_addr = back_diff[AW] ? AW'(back_diff + WIN_SIZE) : back_diff[AW-1:0];
	assign wp_next = (wp_q == WP_MAX) ? '0 : wp_q + 1'b1;

	assign raw = src_mem_q ? rd_data_q : lit_q;
	assign pix = recolor(raw, palette_q, transp_q);
	assign cur_addr = start_q + emit_cnt_q;
	assign out_free = !out_valid_q || out_ready;

	assign sts.act = dec_act;
	assign sts.push_final = !src_mem_q || (copy_left_q == 7'd1);
	assign sts.out_free = out_free;

	assign cfg_ready = 1'b1;
	assign cfg_we = cfg_valid & cfg_ready;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q     <= '0;
			palette_q   <= '0;
			transp_q    <= 1'b0;
			phase_q     <= tlzwd_pkg::PH_HEADER;
			run_left_q  <= '0;
			pend_len_q  <= '0;
			wp_q        <= '0;
			emit_cnt_q  <= '0;
			last_q      <= 1'b0;
			src_mem_q   <= 1'b0;
			copy_left_q <= '0;
			pair_full_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tlzwd_pkg::CFG_START_ADDRESS:    start_q   <= cfg_data;
					tlzwd_pkg::CFG_PALETTE_OFFSET:   palette_q <= cfg_data[7:0];
					tlzwd_pkg::CFG_TRANSPARENT_ZERO: transp_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.accept) begin
				phase_q     <= dec_phase;
				run_left_q  <= dec_run_left;
				pend_len_q  <= dec_pend_len;
				last_q      <= last_byte;
				src_mem_q   <= (dec_act == tlzwd_pkg::ACT_COPY);
				copy_left_q <= dec_copy_len;
				// A last_byte header that emits nothing ends the stream at once
				if (last_byte && (dec_act == tlzwd_pkg::ACT_NONE)) begin
					phase_q    <= tlzwd_pkg::PH_HEADER;
					run_left_q <= '0;
					pend_len_q <= '0;
					wp_q       <= '0;
					emit_cnt_q <= '0;
				end
			end

			if (cmd.push) begin
				wp_q        <= wp_next;
				emit_cnt_q  <= emit_cnt_q + 16'd1;
				copy_left_q <= copy_left_q - 7'd1;
				if (pair_full_q || sts.push_final) begin
					out_valid_q <= 1'b1;
					pair_full_q <= 1'b0;
				end else begin
					pair_full_q <= 1'b1;
				end
			end

			if (cmd.finish && last_q) begin
				phase_q    <= tlzwd_pkg::PH_HEADER;
				run_left_q <= '0;
				pend_len_q <= '0;
				wp_q       <= '0;
				emit_cnt_q <= '0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lit_q  <= dec_lit;
			dist_q <= dec_dist;
		end
		if (cmd.push) begin
			if (pair_full_q) begin
				out_addr_q   <= pair_addr_q;
				out_first_q  <= pair_pix_q;
				out_second_q <= pix;
				out_count_q  <= 2'd2;
				out_end_q    <= sts.push_final;
			end else if (sts.push_final) begin
				out_addr_q   <= cur_addr;
				out_first_q  <= pix;
				out_second_q <= 8'd0;
				out_count_q  <= 2'd1;
				out_end_q    <= 1'b1;
			end else begin
				pair_addr_q <= cur_addr;
				pair_pix_q  <= pix;
			end
		end
	end

	// History window
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			win_mem[wp_q] <= raw;
		end
		if (cmd.rd_en) begin
			rd_data_q <= win_mem[rd_addr];
		end
	end

	assign out_valid    = out_valid_q;
	assign out_address  = out_addr_q;
	assign pixel_first  = out_first_q;
	assign pixel_second = out_second_q;
	assign byte_count   = out_count_q;
	assign run_end      = out_end_q;

	`ASSERT_NEXT(a_finish_flushes_pair, clk, arst_n, cmd.finish, !pair_full_q)
	`ASSERT_IMPLIES(a_single_ends_run, clk, arst_n, out_valid_q && (out_count_q == 2'd1), out_end_q)

endmodule

FILE: rtl/tile_lz_window_decoder.sv
// ----------------------------------------------------------------------------
// tile_lz_window_decoder
// LZ decoder for tile data over a circular history window.
// ----------------------------------------------------------------------------
// Takes one compressed byte per request and returns the tileset bytes that
// it decodes, packed two to a result with the tileset address of the first
// byte, palette offset and transparency applied. A token header that only
// opens a literal run or a long back-reference returns nothing; a literal
// (single, or one byte of a run) pushes one byte; a back-reference of
// length L reads and then pushes each of its bytes, since each copied byte
// needs a registered read of the window RAM before it is written back, so
// an overlapping copy always sees the byte it just produced. Results wait in
// an output register; a push of a new byte stalls only while that register
// is full and not being taken. The window holds no reset: a back-reference
// to a byte not written in the current stream returns undefined data.
// Configuration is written through its own port and takes effect on bytes
// emitted after the write; write it only while the decoder is idle. After
// the request marked last_byte, the decoder phase, window pointer and
// address counter return to their reset values.
// ----------------------------------------------------------------------------
module tile_lz_window_decoder #(
	parameter int WINDOW_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// compressed byte requests
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  comp_byte,
	input  logic        last_byte,
	// decoded results
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] out_address,
	output logic [7:0]  pixel_first,
	output logic [7:0]  pixel_second,
	output logic [1:0]  byte_count,
	output logic        run_end,
	// register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	tlzwd_pkg::cmd_t    cmd;
	tlzwd_pkg::status_t sts;

	// Sequence each request: accept, then read/push per copied byte
	tlzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Decode tokens, hold the window, pair bytes into results
	tlzwd_datapath #(
		.WINDOW_BYTES (WINDOW_BYTES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.comp_byte    (comp_byte),
		.last_byte    (last_byte),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_address  (out_address),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.byte_count   (byte_count),
		.run_end      (run_end)
	);

endmodule

FILE: tb/tile_lz_window_checker.sv
// ----------------------------------------------------------------------------
// tile_lz_window_checker
// Watches the request, result and register channels of the LZ window decoder,
// predicts the results of every accepted compressed byte and compares them,
// oldest first, with what the decoder returns.
// ----------------------------------------------------------------------------
module tile_lz_window_checker
	import tlzwd_pkg::*;
#(
	parameter int WINDOW_BYTES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [7:0]  comp_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] out_address,
	input  logic [7:0]  pixel_first,
	input  logic [7:0]  pixel_second,
	input  logic [1:0]  byte_count,
	input  logic        run_end,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          error_total,
	output int          tiles_pending
);

	localparam int PIXELS_PER_RESULT = 2;
	localparam int REPORT_LIMIT      = 10;

	typedef struct packed {
		logic [15:0] address;
		logic [7:0]  first;
		logic [7:0]  second;
		logic [1:0]  count;
		logic        run_end;
	} tile_result_t;

	logic [7:0]   history [WINDOW_BYTES];
	int unsigned  wr_ptr;
	logic [1:0]   phase;
	logic [6:0]   run_left;
	logic [6:0]   copy_len;
	logic [15:0]  emitted;
	logic [15:0]  base_address;
	logic [7:0]   palette;
	logic         transparent;
	logic [7:0]   fresh_bytes [$];
	tile_result_t expected_tiles [$];
	int           mismatches;

	function automatic logic [7:0] shade(input logic [7:0] raw);
		if (transparent && raw == 8'd0)
			return 8'd0;
		return raw + palette;
	endfunction

	function automatic void store_raw(input logic [7:0] raw);
		history[wr_ptr] = raw;
		wr_ptr = (wr_ptr + 1) % WINDOW_BYTES;
		fresh_bytes.push_back(raw);
	endfunction

	// Byte by byte, so an overlapping copy repeats what it just wrote.
	function automatic void copy_back(input int unsigned length, input int unsigned distance);
		int unsigned k;
		for (k = 0; k < length; k++)
			store_raw(history[(wr_ptr + WINDOW_BYTES - distance) % WINDOW_BYTES]);
	endfunction

	function automatic void decode_request(input logic [7:0] code, input logic stream_end);
		tile_result_t tile;
		int unsigned  n;
		int unsigned  pos;
		fresh_bytes.delete();
		case (phase)
			PH_RUN: begin
				store_raw(code);
				if (run_left != 0)
					run_left--;
				if (run_left == 0)
					phase = PH_HEADER;
			end
			PH_DIST: begin
				copy_back(copy_len, int'(code) + 1);
				copy_len = '0;
				phase = PH_HEADER;
			end
			default: begin
				// an impossible phase falls back to header decoding
				case (code[7:6])
					KIND_LITERAL: store_raw({2'b00, code[5:0]});
					KIND_RUN: begin
						run_left = code[5:0] + 7'd1;
						phase = PH_RUN;
					end
					KIND_SHORT: copy_back(int'(code[5:4]) + 3, int'(code[3:0]) + 1);
					KIND_LONG: begin
						copy_len = code[5:0] + 7'd4;
						phase = PH_DIST;
					end
				endcase
			end
		endcase

		n = fresh_bytes.size();
		for (pos = 0; pos < n; pos += PIXELS_PER_RESULT) begin
			tile.count   = (n - pos >= PIXELS_PER_RESULT) ? 2'd2 : 2'd1;
			tile.address = base_address + emitted + 16'(pos);
			tile.first   = shade(fresh_bytes[pos]);
			tile.second  = (tile.count == 2'd2) ? shade(fresh_bytes[pos + 1]) : 8'd0;
			tile.run_end = (pos + tile.count >= n);
			expected_tiles.push_back(tile);
		end
		emitted = emitted + 16'(n);

		// end of stream: drop any cut-off token, restart pointer and address
		if (stream_end) begin
			wr_ptr   = 0;
			phase    = PH_HEADER;
			run_left = '0;
			copy_len = '0;
			emitted  = '0;
		end
	endfunction

	function automatic void check_tile(input tile_result_t got);
		tile_result_t want;
		if (expected_tiles.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("%0t: unexpected result addr %h first %h second %h count %0d end %b",
					$time, got.address, got.first, got.second, got.count, got.run_end);
			return;
		end
		want = expected_tiles.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT) begin
				$display("%0t: result mismatch", $time);
				$display("  expected addr %h first %h second %h count %0d end %b",
					want.address, want.first, want.second, want.count, want.run_end);
				$display("  actual   addr %h first %h second %h count %0d end %b",
					got.address, got.first, got.second, got.count, got.run_end);
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr       = 0;
			phase        = PH_HEADER;
			run_left     = '0;
			copy_len     = '0;
			emitted      = '0;
			base_address = '0;
			palette      = '0;
			transparent  = 1'b0;
			mismatches   = 0;
			expected_tiles.delete();
			error_total   <= 0;
			tiles_pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_tile({out_address, pixel_first, pixel_second, byte_count, run_end});
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_START_ADDRESS:    base_address = cfg_data;
					CFG_PALETTE_OFFSET:   palette = cfg_data[7:0];
					CFG_TRANSPARENT_ZERO: transparent = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				decode_request(comp_byte, last_byte);
			error_total   <= mismatches;
			tiles_pending <= expected_tiles.size();
		end
	end

endmodule

FILE: tb/tile_lz_window_decoder_tb.sv
// ----------------------------------------------------------------------------
// tile_lz_window_decoder_tb
// Drives compressed LZ streams and register settings into the tile decoder.
// ----------------------------------------------------------------------------
// A short directed stream walks through every token kind, overlapping and
// full-window copies, a register change in the middle of a stream and
// streams cut off inside a token. Then several register settings follow,
// each with random streams, some ending inside a token, whose back-references
// only reach bytes already decoded in the same stream. Both sides idle at
// random; in one setting the result side holds off for a long stretch while
// requests keep coming. The checker beside the decoder predicts and compares.
// ----------------------------------------------------------------------------
module tile_lz_window_decoder_tb;
	import tlzwd_pkg::*;

	localparam int         WINDOW_BYTES  = 256;
	localparam int         CLK_HALF      = 6;
	localparam int         RESET_CYCLES  = 9;
	localparam int         MAX_IDLE      = 16;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         RANDOM_PHASES = 6;
	localparam int         PHASE_ITEMS   = 16;
	localparam int         PRESSURE_PHASE = 3;
	localparam longint     RUN_LIMIT     = 12_000_000;
	// index past the register list; the decoder must ignore it
	localparam logic [1:0] CFG_UNMAPPED  = 2'd3;

	typedef struct {
		logic [7:0] code;
		logic       stream_end;
	} comp_req_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  comp_byte;
	logic        last_byte;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] out_address;
	logic [7:0]  pixel_first;
	logic [7:0]  pixel_second;
	logic [1:0]  byte_count;
	logic        run_end;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	int          error_total;
	int          tiles_pending;

	comp_req_t   request_queue [$];
	bit          sender_rush;   // no gaps between requests
	bit          hold_results;  // ask the result side for one long hold

	tile_lz_window_decoder #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.comp_byte    (comp_byte),
		.last_byte    (last_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_address  (out_address),
		.pixel_first  (pixel_first),
		.pixel_second (pixel_second),
		.byte_count   (byte_count),
		.run_end      (run_end),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	tile_lz_window_checker #(
		.WINDOW_BYTES(WINDOW_BYTES)
	) u_pixel_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.comp_byte     (comp_byte),
		.last_byte     (last_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_address   (out_address),
		.pixel_first   (pixel_first),
		.pixel_second  (pixel_second),
		.byte_count    (byte_count),
		.run_end       (run_end),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.error_total   (error_total),
		.tiles_pending (tiles_pending)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Stream building
	// ------------------------------------------------------------------
	function automatic void add_request(input logic [7:0] code, input logic stream_end = 1'b0);
		comp_req_t req;
		req.code       = code;
		req.stream_end = stream_end;
		request_queue.push_back(req);
	endfunction

	// Zero a quarter of the time so transparency gets real work.
	function automatic logic [7:0] pick_raw(input logic [7:0] mask);
		return ($urandom_range(0, 3) == 0) ? 8'd0 : (8'($urandom) & mask);
	endfunction

	// Append one random stream of about budget requests. produced counts the
	// raw bytes decoded so far, so no back-reference reaches an entry that
	// this stream has not written yet.
	function automatic void build_stream(input int unsigned budget);
		int unsigned produced;
		int unsigned choice;
		int unsigned length;
		int unsigned distance;
		int unsigned reach;
		int unsigned k;
		logic [7:0]  raw;
		comp_req_t   tail;
		produced = 0;
		while (request_queue.size() < budget) begin
			choice = $urandom_range(0, 9);
			if (produced == 0 && choice >= 4)
				choice = 0;
			case (choice)
				0, 1: begin
					raw = pick_raw(8'h3F);
					add_request({KIND_LITERAL, raw[5:0]});
					produced++;
				end
				2, 3: begin
					// mostly short runs, now and then up to the full 64
					length = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 64)
						: $urandom_range(1, 6);
					add_request({KIND_RUN, 6'(length - 1)});
					for (k = 0; k < length; k++)
						add_request(pick_raw(8'hFF));
					produced += length;
				end
				4, 5, 6: begin
					length   = $urandom_range(3, 6);
					distance = $urandom_range(1, (produced < 16) ? produced : 16);
					add_request({KIND_SHORT, 2'(length - 3), 4'(distance - 1)});
					produced += length;
				end
				default: begin
					length   = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 67)
						: $urandom_range(4, 12);
					reach    = (produced < WINDOW_BYTES) ? produced : WINDOW_BYTES;
					distance = $urandom_range(1, reach);
					add_request({KIND_LONG, 6'(length - 4)});
					add_request(8'(distance - 1));
					produced += length;
				end
			endcase
		end
		// now and then end the stream inside a token
		case ($urandom_range(0, 5))
			0: begin
				length = $urandom_range(2, 64);
				add_request({KIND_RUN, 6'(length - 1)});
				for (k = $urandom_range(1, length - 1); k > 0; k--)
					add_request(pick_raw(8'hFF));
			end
			1: add_request({KIND_LONG, 6'($urandom)});
			default: ;
		endcase
		tail = request_queue.pop_back();
		tail.stream_end = 1'b1;
		request_queue.push_back(tail);
	endfunction

	// ------------------------------------------------------------------
	// Channel drivers; every drive lands on a rising edge
	// ------------------------------------------------------------------
	task automatic send_request(input comp_req_t req);
		int unsigned gap;
		gap = sender_rush ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		comp_byte <= req.code;
		last_byte <= req.stream_end;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_queue();
		while (request_queue.size() != 0)
			send_request(request_queue.pop_front());
	endtask

	// Leave cfg_valid high; the caller drops it after its last write.
	task automatic write_reg(input logic [1:0] reg_index, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= reg_index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Upper data bits are noise: only the register width counts.
	task automatic configure(input logic [15:0] start, input logic [7:0] pal, input logic transp);
		write_reg(CFG_START_ADDRESS, start);
		write_reg(CFG_PALETTE_OFFSET, {8'($urandom), pal});
		write_reg(CFG_TRANSPARENT_ZERO, {15'($urandom), transp});
		cfg_valid <= 1'b0;
	endtask

	// Drop the request valid, wait for every predicted result, then give a
	// header-only request time to finish before touching the registers.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tiles_pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_random(input int unsigned items, input bit rush_all);
		int unsigned sent;
		sent = 0;
		while (sent < items) begin
			build_stream($urandom_range(4, 24));
			sent += request_queue.size();
			sender_rush = rush_all || ($urandom_range(0, 3) == 0);
			drain_queue();
		end
	endtask

	// ------------------------------------------------------------------
	// Result side: random stalls, steady stretches, one long hold
	// ------------------------------------------------------------------
	initial begin : result_sink
		int unsigned stall;
		bit          steady;
		out_ready <= 1'b0;
		steady = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 24) == 0)
				steady = !steady;
			stall = steady ? 0 : $urandom_range(0, MAX_IDLE);
			// hold off long enough for the decoder to back up into its input
			if (hold_results) begin
				stall = HOLD_CYCLES;
				hold_results = 1'b0;
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and verdict
	// ------------------------------------------------------------------
	initial begin : stimulus
		int phase_idx;
		arst_n    <= 1'b0;
		in_valid  <= 1'b0;
		comp_byte <= '0;
		last_byte <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		sender_rush  = 1'b0;
		hold_results = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed stream at reset settings: literal extremes, a short run
		// with extreme bytes, then short references at both length ends.
		add_request({KIND_LITERAL, 6'h00});
		add_request({KIND_LITERAL, 6'h3F});
		add_request({KIND_RUN, 6'd2});
		add_request(8'hFF);
		add_request(8'h00);
		add_request(8'hA5);
		add_request({KIND_SHORT, 2'd0, 4'd0});
		add_request({KIND_SHORT, 2'd3, 4'd4});
		drain_queue();
		// change every register in the middle of the stream
		wait_idle();
		configure(16'h8000, 8'h40, 1'b1);
		// longest copy at distance one repeats a single byte; then grow the
		// stream past the window size and finish with a 256-byte reach
		add_request({KIND_LONG, 6'h3F});
		add_request(8'd0);
		add_request({KIND_SHORT, 2'd3, 4'hF});
		add_request({KIND_LONG, 6'h00});
		add_request(8'd86);
		add_request({KIND_LONG, 6'h3F});
		add_request(8'd90);
		add_request({KIND_LONG, 6'h3F});
		add_request(8'd157);
		add_request({KIND_LONG, 6'h3F});
		add_request(8'd224);
		add_request({KIND_LONG, 6'h01});
		add_request(8'hFF, 1'b1);
		// streams cut off inside a run, before a distance and at a header
		add_request({KIND_RUN, 6'd5});
		add_request(8'h11);
		add_request(8'h22, 1'b1);
		add_request({KIND_LONG, 6'h3F}, 1'b1);
		add_request({KIND_RUN, 6'h3F}, 1'b1);
		drain_queue();
		wait_idle();

		for (phase_idx = 1; phase_idx <= RANDOM_PHASES; phase_idx++) begin
			case (phase_idx)
				1: begin
					write_reg(CFG_UNMAPPED, 16'($urandom));
					configure(16'hFFFF, 8'hFF, 1'b1);
				end
				2: configure(16'h0000, 8'h00, 1'b1);
				PRESSURE_PHASE: begin
					configure(16'hFFF0, 8'($urandom), 1'b0);
					hold_results = 1'b1;
				end
				default: configure(16'($urandom), 8'($urandom), 1'($urandom));
			endcase
			run_random(PHASE_ITEMS, phase_idx == PRESSURE_PHASE);
			wait_idle();
		end

		if (error_total == 0 && tiles_pending == 0)
			$display("tile_lz_window_decoder_tb: done, clean");
		else
			$display("tile_lz_window_decoder_tb: done, errors");
		$finish;
	end

	// Stop a hung run.
	initial begin : watchdog
		#(RUN_LIMIT);
		$display("tile_lz_window_decoder_tb: done, errors");
		$finish;
	end

endmodule
